/* rtl/core/tws_pkg.sv */
`timescale 1ns / 1ps

package tws_pkg;

  localparam int unsigned CHAR_W = 8;
  localparam int unsigned STAT_W = 32;

  localparam logic [CHAR_W-1:0] CHAR_NUL = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_TAB = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_LF  = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_SP  = 8'h20;

  // Source of the byte placed in the output register
  typedef enum logic [1:0] {
    SEL_REL,
    SEL_CHR,
    SEL_LF,
    SEL_STAT
  } out_sel_e;

  typedef struct packed {
    logic     accept;
    logic     load_out;
    logic     rel_step;
    out_sel_e sel;
    logic     run_last;
  } tws_cmd_t;

  typedef struct packed {
    logic binary;
    logic is_nul;
    logic is_lf;
    logic is_blank;
    logic fin;
    logic line_started;
    logic del_empty;
    logic held_full;
    logic held_any;
    logic rel_last;
    logic out_free;
  } tws_sts_t;

endpackage

/* rtl/core/tws_if.sv */
`timescale 1ns / 1ps

interface tws_in_if import tws_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] in_char;
  logic              is_final;

  modport source (output valid, output in_char, output is_final, input ready);
  modport sink (input valid, input in_char, input is_final, output ready);
endinterface

interface tws_out_if import tws_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              char_valid;
  logic              run_last;
  logic              binary_found;
  logic [STAT_W-1:0] lines_kept;
  logic [STAT_W-1:0] lines_trimmed;
  logic [STAT_W-1:0] lines_deleted;
  logic [STAT_W-1:0] spaces_removed;
  logic [STAT_W-1:0] tabs_removed;
  logic              text_changed;

  modport source (
    output valid, output out_char, output char_valid, output run_last,
    output binary_found, output lines_kept, output lines_trimmed,
    output lines_deleted, output spaces_removed, output tabs_removed,
    output text_changed, input ready
  );
  modport sink (
    input valid, input out_char, input char_valid, input run_last,
    input binary_found, input lines_kept, input lines_trimmed,
    input lines_deleted, input spaces_removed, input tabs_removed,
    input text_changed, output ready
  );
endinterface

interface tws_cfg_if ();
  logic valid;
  logic ready;
  logic delete_empty_lines;

  modport source (output valid, output delete_empty_lines, input ready);
  modport sink (input valid, input delete_empty_lines, output ready);
endinterface

/* rtl/core/tws_ctrl.sv */
`timescale 1ns / 1ps

module tws_ctrl import tws_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  tws_sts_t sts_i,
  output tws_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_REL  = 5'b00010,
    ST_CHR  = 5'b00100,
    ST_LF   = 5'b01000,
    ST_STAT = 5'b10000
  } tws_state_e;

  tws_state_e state_q, state_d;
  logic       chr_q, chr_d;
  logic       lf_q, lf_d;
  logic       p_rel, p_chr, p_lf;

  // Plan what the request emits, from the state before it is taken
  always_comb begin
    p_rel = 1'b0;
    p_chr = 1'b0;
    p_lf  = 1'b0;
    if (!sts_i.binary && !sts_i.is_nul) begin
      if (sts_i.is_lf) begin
        p_lf = sts_i.line_started || !sts_i.del_empty;
      end else if (sts_i.is_blank) begin
        p_rel = sts_i.held_full;
        p_lf  = sts_i.fin;
      end else begin
        p_rel = sts_i.held_any;
        p_chr = 1'b1;
        p_lf  = sts_i.fin;
      end
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d      = state_q;
    chr_d        = chr_q;
    lf_d         = lf_q;
    cmd_o        = '0;
    cmd_o.sel    = SEL_STAT;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          chr_d        = p_chr;
          lf_d         = p_lf;
          if (p_rel) begin
            state_d = ST_REL;
          end else if (p_chr) begin
            state_d = ST_CHR;
          end else if (p_lf) begin
            state_d = ST_LF;
          end else begin
            state_d = ST_STAT;
          end
        end
      end
      ST_REL: begin
        cmd_o.sel      = SEL_REL;
        cmd_o.run_last = sts_i.rel_last && !chr_q && !lf_q;
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.rel_step = 1'b1;
          if (sts_i.rel_last) begin
            if (chr_q) begin
              state_d = ST_CHR;
            end else if (lf_q) begin
              state_d = ST_LF;
            end else begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      ST_CHR: begin
        cmd_o.sel      = SEL_CHR;
        cmd_o.run_last = !lf_q;
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = lf_q ? ST_LF : ST_IDLE;
        end
      end
      ST_LF: begin
        cmd_o.sel      = SEL_LF;
        cmd_o.run_last = 1'b1;
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_STAT: begin
        cmd_o.sel      = SEL_STAT;
        cmd_o.run_last = 1'b1;
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      chr_q   <= 1'b0;
      lf_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      chr_q   <= chr_d;
      lf_q    <= lf_d;
    end
  end

endmodule

/* rtl/core/tws_dp.sv */
`timescale 1ns / 1ps

module tws_dp import tws_pkg::*; #(
  parameter int unsigned HOLD_DEPTH  = 62,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [CHAR_W-1:0] in_char_i,
  input  logic              is_final_i,
  input  logic              cfg_we_i,
  input  logic              cfg_data_i,
  input  tws_cmd_t          cmd_i,
  output tws_sts_t          sts_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [CHAR_W-1:0] out_char_o,
  output logic              char_valid_o,
  output logic              run_last_o,
  output logic              binary_found_o,
  output logic [STAT_W-1:0] lines_kept_o,
  output logic [STAT_W-1:0] lines_trimmed_o,
  output logic [STAT_W-1:0] lines_deleted_o,
  output logic [STAT_W-1:0] spaces_removed_o,
  output logic [STAT_W-1:0] tabs_removed_o,
  output logic              text_changed_o
);

  localparam int unsigned IDX_W = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(HOLD_DEPTH + 1);
  localparam logic [CNT_W-1:0] HOLD_FULL = CNT_W'(HOLD_DEPTH);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef logic [COUNT_WIDTH-1:0] cnt_t;

  function automatic cnt_t sat_add(input cnt_t a, input logic [CNT_W-1:0] b);
    logic [COUNT_WIDTH:0] sum;
    sum = {1'b0, a} + (COUNT_WIDTH + 1)'(b);
    return sum[COUNT_WIDTH] ? CNT_MAX : sum[COUNT_WIDTH-1:0];
  endfunction

  // Held run: one bit per blank, 1 = tab
  logic             mem [HOLD_DEPTH];
  logic             rd_q;
  logic [IDX_W-1:0] rd_addr, wr_addr;

  logic [CNT_W-1:0] held_cnt_q, held_cnt_d;
  logic [CNT_W-1:0] held_sp_q, held_sp_d;
  logic [CNT_W-1:0] held_tab_q, held_tab_d;
  logic [CNT_W-1:0] rel_cnt_q, rel_cnt_d, rel_cnt_nx;
  logic [CNT_W-1:0] rel_len_q, rel_len_d;
  logic [CNT_W-1:0] base_cnt, base_sp, base_tab, new_cnt, new_sp, new_tab;
  logic             line_q, line_d;
  logic             bin_q, bin_d;
  logic             del_q;
  cnt_t             kept_q, kept_d, trim_q, trim_d, delc_q, delc_d;
  cnt_t             sp_q, sp_d, tab_q, tab_d;
  logic [CHAR_W-1:0] char_q;
  logic             out_valid_q;
  logic             is_nul, is_lf, is_sp, is_tab, is_blank, held_full, wr_en;

  assign is_nul    = (in_char_i == CHAR_NUL);
  assign is_lf     = (in_char_i == CHAR_LF);
  assign is_sp     = (in_char_i == CHAR_SP);
  assign is_tab    = (in_char_i == CHAR_TAB);
  assign is_blank  = is_sp || is_tab;
  assign held_full = (held_cnt_q == HOLD_FULL);

  // A full run is released before the new blank joins it
  assign base_cnt = held_full ? '0 : held_cnt_q;
  assign base_sp  = held_full ? '0 : held_sp_q;
  assign base_tab = held_full ? '0 : held_tab_q;
  assign new_cnt  = CNT_W'(base_cnt + 1'b1);
  assign new_sp   = CNT_W'(base_sp + CNT_W'(!is_tab));
  assign new_tab  = CNT_W'(base_tab + CNT_W'(is_tab));

  assign rel_cnt_nx = CNT_W'(rel_cnt_q + 1'b1);

  always_comb begin
    held_cnt_d = held_cnt_q;
    held_sp_d  = held_sp_q;
    held_tab_d = held_tab_q;
    line_d     = line_q;
    bin_d      = bin_q;
    kept_d     = kept_q;
    trim_d     = trim_q;
    delc_d     = delc_q;
    sp_d       = sp_q;
    tab_d      = tab_q;
    rel_cnt_d  = rel_cnt_q;
    rel_len_d  = rel_len_q;
    wr_en      = 1'b0;
    if (cmd_i.rel_step) begin
      rel_cnt_d = rel_cnt_nx;
    end
    if (cmd_i.accept) begin
      rel_cnt_d = '0;
      rel_len_d = held_cnt_q;
      if (!bin_q) begin
        if (is_nul) begin
          bin_d      = 1'b1;
          held_cnt_d = '0;
          held_sp_d  = '0;
          held_tab_d = '0;
          line_d     = 1'b0;
        end else if (is_lf) begin
          if (held_cnt_q != '0) begin
            sp_d   = sat_add(sp_q, held_sp_q);
            tab_d  = sat_add(tab_q, held_tab_q);
            trim_d = sat_add(trim_q, CNT_W'(1));
          end
          if (!line_q && del_q) begin
            delc_d = sat_add(delc_q, CNT_W'(1));
          end else begin
            kept_d = sat_add(kept_q, CNT_W'(1));
          end
          held_cnt_d = '0;
          held_sp_d  = '0;
          held_tab_d = '0;
          line_d     = 1'b0;
        end else if (is_blank) begin
          wr_en      = 1'b1;
          held_cnt_d = new_cnt;
          held_sp_d  = new_sp;
          held_tab_d = new_tab;
          line_d     = 1'b1;
          if (is_final_i) begin
            sp_d       = sat_add(sp_q, new_sp);
            tab_d      = sat_add(tab_q, new_tab);
            trim_d     = sat_add(trim_q, CNT_W'(1));
            kept_d     = sat_add(kept_q, CNT_W'(1));
            held_cnt_d = '0;
            held_sp_d  = '0;
            held_tab_d = '0;
            line_d     = 1'b0;
          end
        end else begin
          held_cnt_d = '0;
          held_sp_d  = '0;
          held_tab_d = '0;
          line_d     = 1'b1;
          if (is_final_i) begin
            kept_d = sat_add(kept_q, CNT_W'(1));
            line_d = 1'b0;
          end
        end
      end
    end
  end

  // Read entry zero on accept (before any overwrite), then step through the run
  assign wr_addr = held_full ? '0 : held_cnt_q[IDX_W-1:0];
  assign rd_addr = (cmd_i.rel_step && (rel_cnt_nx < HOLD_FULL)) ?
                   rel_cnt_nx[IDX_W-1:0] : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept || cmd_i.rel_step) begin
      rd_q <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= is_tab;
    end
    if (cmd_i.accept) begin
      char_q <= in_char_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_cnt_q  <= '0;
      held_sp_q   <= '0;
      held_tab_q  <= '0;
      rel_cnt_q   <= '0;
      rel_len_q   <= '0;
      line_q      <= 1'b0;
      bin_q       <= 1'b0;
      del_q       <= 1'b0;
      kept_q      <= '0;
      trim_q      <= '0;
      delc_q      <= '0;
      sp_q        <= '0;
      tab_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      held_cnt_q <= held_cnt_d;
      held_sp_q  <= held_sp_d;
      held_tab_q <= held_tab_d;
      rel_cnt_q  <= rel_cnt_d;
      rel_len_q  <= rel_len_d;
      line_q     <= line_d;
      bin_q      <= bin_d;
      kept_q     <= kept_d;
      trim_q     <= trim_d;
      delc_q     <= delc_d;
      sp_q       <= sp_d;
      tab_q      <= tab_d;
      if (cfg_we_i) begin
        del_q <= cfg_data_i;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output register: counters are snapshotted with each result
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      case (cmd_i.sel)
        SEL_REL: out_char_o <= rd_q ? CHAR_TAB : CHAR_SP;
        SEL_CHR: out_char_o <= char_q;
        SEL_LF:  out_char_o <= CHAR_LF;
        default: out_char_o <= CHAR_NUL;
      endcase
      char_valid_o     <= (cmd_i.sel != SEL_STAT);
      run_last_o       <= cmd_i.run_last;
      binary_found_o   <= bin_q;
      lines_kept_o     <= STAT_W'(kept_q);
      lines_trimmed_o  <= STAT_W'(trim_q);
      lines_deleted_o  <= STAT_W'(delc_q);
      spaces_removed_o <= STAT_W'(sp_q);
      tabs_removed_o   <= STAT_W'(tab_q);
      text_changed_o   <= (trim_q != '0) || (delc_q != '0);
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    sts_o              = '0;
    sts_o.binary       = bin_q;
    sts_o.is_nul       = is_nul;
    sts_o.is_lf        = is_lf;
    sts_o.is_blank     = is_blank;
    sts_o.fin          = is_final_i;
    sts_o.line_started = line_q;
    sts_o.del_empty    = del_q;
    sts_o.held_full    = held_full;
    sts_o.held_any     = (held_cnt_q != '0);
    sts_o.rel_last     = (rel_cnt_nx == rel_len_q);
    sts_o.out_free     = !out_valid_q || out_ready_i;
  end

endmodule

/* rtl/core/trailing_whitespace_stripper.sv */
`timescale 1ns / 1ps
// Trailing whitespace filter for a byte stream.
// in_i  : one text byte per request (in_char, is_final), valid/ready.
// out_o : result requests; one per passed byte, or a single status-only request
//         (char_valid low) when a byte passes nothing on. run_last marks the
//         final request caused by an input byte. Counters ride on every request.
// cfg_i : write of delete_empty_lines; always ready, take it while idle.
// Sequence: an ordinary byte is accepted, then loaded once into the output
// register. A byte that releases a held run of n blanks emits them one at
// a time before itself, paced by the single read port of the blank-run
// memory; a final byte that closes its line adds a line feed. The first
// result of a byte is loaded after accept, once the output register is free.
// Reset: counters, held run length, line and binary flags and the output valid
// flag clear at once; the blank-run memory is not cleared and needs no sweep.
// Receiver stall: the output register holds its request and the block stops
// emitting; a new input byte is still taken once the previous byte has loaded
// its last result, so one request can wait while the next is accepted.
module trailing_whitespace_stripper import tws_pkg::*; #(
  parameter int unsigned HOLD_DEPTH  = 62,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  tws_in_if.sink    in_i,
  tws_out_if.source out_o,
  tws_cfg_if.sink   cfg_i
);

  tws_cmd_t cmd;
  tws_sts_t sts;

  // Configuration writes never stall
  assign cfg_i.ready = 1'b1;

  // Sequencer: accept, then release held blanks, the byte, and the line feed, or a status-only result
  tws_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Line state, counters, blank-run memory and output register
  tws_dp #(
    .HOLD_DEPTH  (HOLD_DEPTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_char_i        (in_i.in_char),
    .is_final_i       (in_i.is_final),
    .cfg_we_i         (cfg_i.valid),
    .cfg_data_i       (cfg_i.delete_empty_lines),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_ready_i      (out_o.ready),
    .out_valid_o      (out_o.valid),
    .out_char_o       (out_o.out_char),
    .char_valid_o     (out_o.char_valid),
    .run_last_o       (out_o.run_last),
    .binary_found_o   (out_o.binary_found),
    .lines_kept_o     (out_o.lines_kept),
    .lines_trimmed_o  (out_o.lines_trimmed),
    .lines_deleted_o  (out_o.lines_deleted),
    .spaces_removed_o (out_o.spaces_removed),
    .tabs_removed_o   (out_o.tabs_removed),
    .text_changed_o   (out_o.text_changed)
  );

  // The last request of a byte hands control back to input acceptance
  a_last_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out && cmd.run_last |=> in_i.ready)
    else $error("input not ready after last result of a byte");

  // Never overwrite a request the receiver has not taken
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> sts.out_free)
    else $error("output register loaded while occupied");

  // Accepting and emitting are separate phases
  a_accept_no_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.accept |-> !cmd.load_out)
    else $error("accept and output load in the same cycle");

  // Binary flag only clears through reset
  a_binary_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(sts.binary))
    else $error("binary flag dropped");

endmodule
